// ===== design/bdg_pkg.sv =====
// Shared types, constants and helpers for the button debounce / gesture block.
// No dependencies; used by bdg_debounce, bdg_gesture and the top level.
package bdg_pkg;

  localparam int unsigned CFG_WIDTH     = 16;
  localparam int unsigned TAP_WIDTH     = 8;
  localparam int unsigned COUNT_WIDTH   = 32;
  localparam int unsigned AGE_WIDTH_DEF = 16;
  localparam int unsigned TAP_LIMIT_DEF = 255;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd3;
  localparam logic [CFG_WIDTH-1:0] HOLD_RST     = 16'd40;
  localparam logic [CFG_WIDTH-1:0] LONG_RST     = 16'd300;
  localparam logic [CFG_WIDTH-1:0] SETTLE_RST   = 16'd40;

  // taps before a hold needed for the tap-hold gesture
  localparam logic [TAP_WIDTH-1:0] TAP_HOLD_MIN = 8'd2;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_HOLD       = 2'd1,
    REG_LONG_LIMIT = 2'd2,
    REG_SETTLE     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    G_NONE       = 3'd0,
    G_HOLD_BEGIN = 3'd1,
    G_HOLD_END   = 3'd2,
    G_SINGLE     = 3'd3,
    G_DOUBLE     = 3'd4,
    G_TRIPLE     = 3'd5,
    G_QUINT      = 3'd6,
    G_TAP_HOLD   = 3'd7
  } gesture_t;

  typedef struct packed {
    logic press;
    logic release_e;
  } edge_t;

  function automatic gesture_t tap_gesture(input logic [TAP_WIDTH-1:0] taps);
    gesture_t g;
    unique case (taps)
      8'd1:    g = G_SINGLE;
      8'd2:    g = G_DOUBLE;
      8'd3:    g = G_TRIPLE;
      8'd5:    g = G_QUINT;
      default: g = G_NONE;
    endcase
    return g;
  endfunction

endpackage

// ===== design/bdg_debounce.sv =====
// Debounce filter: candidate level, saturating persistence age, stable level
// and press edge counter. Uses bdg_pkg.
module bdg_debounce #(
  parameter int unsigned AGE_WIDTH = bdg_pkg::AGE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              level,
  input  logic [bdg_pkg::CFG_WIDTH-1:0]     debounce_ticks,
  output bdg_pkg::edge_t                    edges,
  output logic                              stable_next,
  output logic [bdg_pkg::COUNT_WIDTH-1:0]   press_count_next
);

  localparam int unsigned CMP_W = (AGE_WIDTH > bdg_pkg::CFG_WIDTH) ?
                                  AGE_WIDTH : bdg_pkg::CFG_WIDTH;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

  logic                              candidate_level, candidate_level_next;
  logic                              stable_level;
  logic [AGE_WIDTH-1:0]              candidate_age, candidate_age_next;
  logic [bdg_pkg::COUNT_WIDTH-1:0]   press_counter;

  always_comb begin
    candidate_level_next = candidate_level;
    candidate_age_next   = candidate_age;
    stable_next          = stable_level;
    press_count_next     = press_counter;
    edges                = '0;
    if (level != candidate_level) begin
      candidate_level_next = level;
      candidate_age_next   = '0;
    end else begin
      candidate_age_next = (candidate_age == AGE_MAX) ? AGE_MAX : candidate_age + 1'b1;
      if ((CMP_W'(candidate_age_next) > CMP_W'(debounce_ticks)) &&
          (candidate_level != stable_level)) begin
        stable_next = candidate_level;
        if (candidate_level) begin
          press_count_next = press_counter + 1'b1;
          edges.press      = 1'b1;
        end else begin
          edges.release_e = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_level <= 1'b0;
      stable_level    <= 1'b0;
      candidate_age   <= '0;
      press_counter   <= '0;
    end else if (step) begin
      candidate_level <= candidate_level_next;
      stable_level    <= stable_next;
      candidate_age   <= candidate_age_next;
      press_counter   <= press_count_next;
    end
  end

endmodule

// ===== design/bdg_gesture.sv =====
// Gesture state machine: turns debounced edges into hold and tap gestures.
// Uses bdg_pkg.
module bdg_gesture #(
  parameter int unsigned AGE_WIDTH = bdg_pkg::AGE_WIDTH_DEF,
  parameter int unsigned TAP_LIMIT = bdg_pkg::TAP_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  bdg_pkg::edge_t                 edges,
  input  logic [bdg_pkg::CFG_WIDTH-1:0]  hold_ticks,
  input  logic [bdg_pkg::CFG_WIDTH-1:0]  long_ticks,
  input  logic [bdg_pkg::CFG_WIDTH-1:0]  settle_ticks,
  output bdg_pkg::gesture_t              gesture_next,
  output logic                           long_flag_next,
  output logic                           holding_next
);

  localparam int unsigned CMP_W = (AGE_WIDTH > bdg_pkg::CFG_WIDTH) ?
                                  AGE_WIDTH : bdg_pkg::CFG_WIDTH;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};
  localparam logic [bdg_pkg::TAP_WIDTH-1:0] TAP_MAX = bdg_pkg::TAP_WIDTH'(TAP_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DOWN = 4'b0010,
    S_HELD = 4'b0100,
    S_TAPS = 4'b1000
  } state_t;

  state_t                          state, state_next;
  logic [bdg_pkg::TAP_WIDTH-1:0]   tap_tally, tap_tally_next;
  logic [AGE_WIDTH-1:0]            press_age, press_age_next;
  logic [AGE_WIDTH-1:0]            release_age, release_age_next;
  logic                            long_done, long_done_next;
  logic                            hold_flag;

  // Steps apply in order; later ones see the state left by earlier ones.
  always_comb begin
    press_age_next   = (press_age == AGE_MAX) ? AGE_MAX : press_age + 1'b1;
    release_age_next = (release_age == AGE_MAX) ? AGE_MAX : release_age + 1'b1;
    state_next       = state;
    tap_tally_next   = tap_tally;
    long_done_next   = long_done;
    holding_next     = hold_flag;
    gesture_next     = bdg_pkg::G_NONE;
    long_flag_next   = 1'b0;

    if (edges.press) begin
      press_age_next = '0;
      long_done_next = 1'b0;
      state_next     = S_DOWN;
    end else if (edges.release_e) begin
      release_age_next = '0;
      if (state == S_HELD) begin
        holding_next   = 1'b0;
        gesture_next   = (tap_tally >= bdg_pkg::TAP_HOLD_MIN) ?
                         bdg_pkg::G_TAP_HOLD : bdg_pkg::G_HOLD_END;
        tap_tally_next = '0;
        state_next     = S_IDLE;
      end else begin
        if (tap_tally < TAP_MAX) tap_tally_next = tap_tally + 1'b1;
        state_next = S_TAPS;
      end
    end

    if (state_next == S_DOWN &&
        CMP_W'(press_age_next) > CMP_W'(hold_ticks)) begin
      state_next   = S_HELD;
      holding_next = 1'b1;
      gesture_next = bdg_pkg::G_HOLD_BEGIN;
    end

    if (state_next == S_HELD && !long_done_next &&
        CMP_W'(press_age_next) > CMP_W'(long_ticks)) begin
      long_done_next = 1'b1;
      long_flag_next = 1'b1;
    end

    if (state_next == S_TAPS &&
        CMP_W'(release_age_next) > CMP_W'(settle_ticks)) begin
      gesture_next   = bdg_pkg::tap_gesture(tap_tally_next);
      tap_tally_next = '0;
      state_next     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tap_tally   <= '0;
      press_age   <= '0;
      release_age <= '0;
      long_done   <= 1'b0;
      hold_flag   <= 1'b0;
    end else if (step) begin
      state       <= state_next;
      tap_tally   <= tap_tally_next;
      press_age   <= press_age_next;
      release_age <= release_age_next;
      long_done   <= long_done_next;
      hold_flag   <= holding_next;
    end
  end

endmodule

// ===== design/button_debounce_gesture_detector_core.sv =====
// Button debounce and tap/hold gesture detector, top level.
// Each accepted sample beat's result is registered onto m_tdata in the next cycle.
// Throughput: one sample per cycle; s_tready drops only while a result waits.
// Reset (rst, synchronous): filter, gesture and m_tvalid state cleared, config registers back to defaults.
// Depends on bdg_pkg, bdg_debounce, bdg_gesture.
module button_debounce_gesture_detector_core #(
  parameter int unsigned AGE_WIDTH = bdg_pkg::AGE_WIDTH_DEF,
  parameter int unsigned TAP_LIMIT = bdg_pkg::TAP_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [0] pin_level
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [2:0] gesture, [3] long_flag, [4] pressed_now, [5] holding_now,
  // [37:6] press_total
  output logic [39:0]                    m_tdata,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [bdg_pkg::CFG_WIDTH-1:0]  cfg_data
);

  logic [bdg_pkg::CFG_WIDTH-1:0]    debounce_ticks, hold_ticks, long_ticks, settle_ticks;
  logic                             accept;
  bdg_pkg::edge_t                   edges;
  logic                             stable_next, long_flag_next, holding_next;
  logic [bdg_pkg::COUNT_WIDTH-1:0]  press_count_next;
  bdg_pkg::gesture_t                gesture_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= bdg_pkg::DEBOUNCE_RST;
      hold_ticks     <= bdg_pkg::HOLD_RST;
      long_ticks     <= bdg_pkg::LONG_RST;
      settle_ticks   <= bdg_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      unique case (bdg_pkg::cfg_reg_t'(cfg_index))
        bdg_pkg::REG_DEBOUNCE:   debounce_ticks <= cfg_data;
        bdg_pkg::REG_HOLD:       hold_ticks     <= cfg_data;
        bdg_pkg::REG_LONG_LIMIT: long_ticks     <= cfg_data;
        bdg_pkg::REG_SETTLE:     settle_ticks   <= cfg_data;
      endcase
    end
  end

  bdg_debounce #(.AGE_WIDTH(AGE_WIDTH)) u_debounce (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .level            (s_tdata[0]),
    .debounce_ticks   (debounce_ticks),
    .edges            (edges),
    .stable_next      (stable_next),
    .press_count_next (press_count_next)
  );

  bdg_gesture #(.AGE_WIDTH(AGE_WIDTH), .TAP_LIMIT(TAP_LIMIT)) u_gesture (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .edges          (edges),
    .hold_ticks     (hold_ticks),
    .long_ticks     (long_ticks),
    .settle_ticks   (settle_ticks),
    .gesture_next   (gesture_next),
    .long_flag_next (long_flag_next),
    .holding_next   (holding_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, press_count_next, holding_next, stable_next,
                  long_flag_next, gesture_next};
    end
  end

`ifndef SYNTHESIS
  // a committed hold implies the button is still down
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[4])
    else $error("holding_now without pressed_now");

  // long flag only fires while holding
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[5])
    else $error("long flag outside a hold");

  // hold begin always leaves the hold committed
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == bdg_pkg::G_HOLD_BEGIN |-> m_tdata[5])
    else $error("hold begin without holding_now");

  // a stalled result beat stays put
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");
`endif

endmodule
